/* design/mor_pkg.sv */
// Shared types and constants for the max-ones-rectangle-on-border block.
// No dependencies; imported by mor_cell and the top level.
package mor_pkg;

   localparam int DEF_MAX_ROWS = 256;
   localparam int DEF_MAX_COLS = 256;
   localparam int COORD_W      = 8;
   localparam int COORD_LIMIT  = 256;
   localparam int CFG_W        = 9;
   localparam int OP_W         = 2;
   localparam int AREA_W       = 17;
   localparam int CSR_IDX_W    = 1;

   localparam logic [AREA_W-1:0] AREA_MAX = 17'h1FFFF;
   localparam logic [CFG_W-1:0]  SIZE_RESET = 9'd256;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_TOGGLE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   // Control of one run-length cell.
   typedef struct packed {
      logic clear;
      logic accum;
      logic shift;
   } cell_ctl_type;

endpackage

/* design/mor_cell.sv */
// One run-length cell of the chain: counts a run of ones, then shifts toward the head.
// Depends on mor_pkg for the cell control struct.
module mor_cell #(
   parameter int LW = 9
) (
   input  logic                  clock,
   input  mor_pkg::cell_ctl_type ctl,
   input  logic                  bit_in,
   input  logic [LW-1:0]         next_run,
   output logic [LW-1:0]         run
);
   import mor_pkg::*;

   logic [LW-1:0] run_ff, run_in;
   logic          alive_ff, alive_in;

   always_comb begin
      run_in   = run_ff;
      alive_in = alive_ff;
      if (ctl.clear) begin
         run_in   = '0;
         alive_in = 1'b1;
      end else if (ctl.accum) begin
         if (alive_ff && bit_in) begin
            run_in = run_ff + LW'(1);
         end else begin
            alive_in = 1'b0;
         end
      end else if (ctl.shift) begin
         run_in = next_run;
      end
   end

   always_ff @(posedge clock) begin
      run_ff   <= run_in;
      alive_ff <= alive_in;
   end

   assign run = run_ff;

endmodule

/* design/mor_grid.sv */
// Pixel grid storage: a row-major and a column-major copy, one registered read a cycle.
// Standalone; sizes come from the top level's parameters.
module mor_grid #(
   parameter int NROW = 256,
   parameter int NCOL = 256,
   parameter int LINE = 256,
   parameter int LW   = 9
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [LW-1:0]   wr_row,
   input  logic [LW-1:0]   wr_col,
   input  logic            wr_bit,
   input  logic            rd_col_sel,
   input  logic [LW-1:0]   rd_addr,
   output logic [LINE-1:0] rd_word
);
   localparam int RAW = (NROW > 1) ? $clog2(NROW) : 1;
   localparam int CAW = (NCOL > 1) ? $clog2(NCOL) : 1;

   logic [NCOL-1:0] row_mem [NROW];
   logic [NROW-1:0] col_mem [NCOL];
   logic [NCOL-1:0] row_rd_ff;
   logic [NROW-1:0] col_rd_ff;
   logic            sel_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_row[RAW-1:0]][wr_col[CAW-1:0]] <= wr_bit;
         col_mem[wr_col[CAW-1:0]][wr_row[RAW-1:0]] <= wr_bit;
      end
      row_rd_ff <= row_mem[rd_addr[RAW-1:0]];
      col_rd_ff <= col_mem[rd_addr[CAW-1:0]];
      sel_ff    <= rd_col_sel;
   end

   assign rd_word = sel_ff ? LINE'(col_rd_ff) : LINE'(row_rd_ff);

endmodule

/* design/max_ones_rectangle_on_border_core.sv */
// Top level of the max-ones-rectangle-on-border block: control, cell chains, area search.
// Depends on mor_pkg, mor_cell and mor_grid.
//
//   channel | direction | handshake          | contents
//   req     | in        | req_valid/req_stall | operation, row, col, pixel
//   rsp     | out       | rsp_valid/rsp_stall | area (queries only)
//   csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// Each of the four directions of a query scans one stored line a cycle through the single
// memory read port, then takes one greedy widening step a cycle. Reset is synchronous and
// restores a 256 by 256 size; the pixel memories are not cleared. A request is taken only
// while the control is idle, and a finished response waits in the output register while
// rsp_stall is high.
module max_ones_rectangle_on_border_core #(
   parameter int MAX_ROWS = mor_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = mor_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mor_pkg::OP_W-1:0]        req_operation,
   input  logic [mor_pkg::COORD_W-1:0]     req_row,
   input  logic [mor_pkg::COORD_W-1:0]     req_col,
   input  logic                            req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mor_pkg::AREA_W-1:0]      rsp_area,
   input  logic                            csr_wr_en,
   input  logic [mor_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mor_pkg::CFG_W-1:0]       csr_wdata
);
   import mor_pkg::*;

   // Coordinates are eight bits wide, so no more than COORD_LIMIT lines are ever stored.
   localparam int NROW = (MAX_ROWS < COORD_LIMIT) ? MAX_ROWS : COORD_LIMIT;
   localparam int NCOL = (MAX_COLS < COORD_LIMIT) ? MAX_COLS : COORD_LIMIT;
   localparam int LINE = (NROW > NCOL) ? NROW : NCOL;
   localparam int LW   = $clog2(LINE + 1);
   localparam int PW   = 2 * LW;
   localparam int SW   = PW + AREA_W;

   typedef enum logic [2:0] {
      S_IDLE, S_TGL, S_SETUP, S_RUN, S_GINIT, S_GREEDY, S_FLUSH, S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [1:0]          dir_ff, dir_in;
   logic [LW-1:0]       k_ff, k_in;
   logic [LW-1:0]       low_ff, low_in;
   logic [LW-1:0]       width_ff, width_in;
   logic [LW-1:0]       lcnt_ff, lcnt_in;
   logic [LW-1:0]       rcnt_ff, rcnt_in;
   logic [LW-1:0]       n_ff, n_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [PW-1:0]       best_ff, best_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0]   rsp_area_ff, rsp_area_in;
   logic [COORD_W-1:0]  row_ff, row_in;
   logic [COORD_W-1:0]  col_ff, col_in;
   logic [CFG_W-1:0]    rows_ff, rows_in;
   logic [CFG_W-1:0]    cols_ff, cols_in;

   logic [LW-1:0]   nr, nc, p_cur, n_cur, base, lim, len, rd_addr, val;
   logic            in_grid, accept, issue, go, take_left, step;
   logic            wr_en, wr_bit, rd_col_sel, cur_bit, c_bit;
   logic [LW-1:0]   wr_row, wr_col;
   logic [LINE-1:0] rd_word, rev_word, l_bits, r_bits, rot_word, c_word;
   logic [LW-1:0]   l_run [LINE];
   logic [LW-1:0]   r_run [LINE];
   logic [LW-1:0]   l_next [LINE];
   logic [LW-1:0]   r_next [LINE];
   logic [LW-1:0]   c_run;
   logic [SW-1:0]   best_wide;
   cell_ctl_type    l_ctl, r_ctl, c_ctl;

   // Sizes in use, clamped to what is stored.
   assign nr = (int'(rows_ff) > NROW) ? LW'(NROW) : LW'(rows_ff);
   assign nc = (int'(cols_ff) > NCOL) ? LW'(NCOL) : LW'(cols_ff);

   assign in_grid = (int'(req_row) < int'(nr)) && (int'(req_col) < int'(nc));
   assign accept = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);

   // Directions: 0 queried row on top, 1 on bottom, 2 queried column on left, 3 on right.
   // Rows are scanned for the first two, columns for the last two.
   assign p_cur = dir_ff[1] ? LW'(row_ff) : LW'(col_ff);
   assign n_cur = dir_ff[1] ? nr : nc;
   assign base  = dir_ff[1] ? LW'(col_ff) : LW'(row_ff);
   assign lim   = dir_ff[1] ? nc : nr;
   assign len   = dir_ff[0] ? (base + LW'(1)) : (lim - base);
   assign issue = (state_ff == S_RUN) && (k_ff < len);

   assign rd_addr    = (state_ff == S_RUN) ? (dir_ff[0] ? (base - k_ff) : (base + k_ff))
                                           : LW'(req_row);
   assign rd_col_sel = (state_ff == S_RUN) && dir_ff[1];

   // A toggle reads the row in the accept cycle and writes the inverted bit next cycle.
   assign rot_word = rd_word >> LW'(col_ff);
   assign cur_bit  = rot_word[0];
   assign wr_en  = (accept && (req_operation == OP_LOAD) && in_grid) || (state_ff == S_TGL);
   assign wr_row = (state_ff == S_TGL) ? LW'(row_ff) : LW'(req_row);
   assign wr_col = (state_ff == S_TGL) ? LW'(col_ff) : LW'(req_col);
   assign wr_bit = (state_ff == S_TGL) ? ~cur_bit : req_pixel;

   mor_grid #(
      .NROW (NROW),
      .NCOL (NCOL),
      .LINE (LINE),
      .LW   (LW)
   ) u_grid (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_row     (wr_row),
      .wr_col     (wr_col),
      .wr_bit     (wr_bit),
      .rd_col_sel (rd_col_sel),
      .rd_addr    (rd_addr),
      .rd_word    (rd_word)
   );

   // Align the scanned line so that the cell heads sit next to the queried position:
   // right chain cell j sees position p+1+j, left chain cell j sees position p-1-j.
   always_comb begin
      for (int i = 0; i < LINE; i++) begin
         rev_word[i] = rd_word[LINE-1-i];
      end
   end
   assign l_bits = rev_word >> (LW'(LINE) - p_cur);
   assign r_bits = rd_word >> (p_cur + LW'(1));
   assign c_word = rd_word >> p_cur;
   assign c_bit  = c_word[0];

   // Greedy widening: extend toward the larger neighbor run, one step a cycle.
   assign go        = (low_ff != '0) && ((lcnt_ff != '0) || (rcnt_ff != '0));
   assign take_left = (lcnt_ff != '0) && ((rcnt_ff == '0) || (l_run[0] >= r_run[0]));
   assign val       = take_left ? l_run[0] : r_run[0];
   assign step      = (state_ff == S_GREEDY) && go;

   assign l_ctl = '{clear: (state_ff == S_SETUP), accum: rd_valid_ff, shift: step && take_left};
   assign r_ctl = '{clear: (state_ff == S_SETUP), accum: rd_valid_ff, shift: step && !take_left};
   assign c_ctl = '{clear: (state_ff == S_SETUP), accum: rd_valid_ff, shift: 1'b0};

   for (genvar j = 0; j < LINE; j++) begin : g_chain
      if (j < LINE - 1) begin : g_mid
         assign l_next[j] = l_run[j+1];
         assign r_next[j] = r_run[j+1];
      end else begin : g_end
         assign l_next[j] = '0;
         assign r_next[j] = '0;
      end

      mor_cell #(.LW(LW)) u_left (
         .clock    (clock),
         .ctl      (l_ctl),
         .bit_in   (l_bits[j]),
         .next_run (l_next[j]),
         .run      (l_run[j])
      );

      mor_cell #(.LW(LW)) u_right (
         .clock    (clock),
         .ctl      (r_ctl),
         .bit_in   (r_bits[j]),
         .next_run (r_next[j]),
         .run      (r_run[j])
      );
   end

   mor_cell #(.LW(LW)) u_center (
      .clock    (clock),
      .ctl      (c_ctl),
      .bit_in   (c_bit),
      .next_run ('0),
      .run      (c_run)
   );

   assign best_wide = SW'(best_ff);

   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      k_in         = k_ff;
      low_in       = low_ff;
      width_in     = width_ff;
      lcnt_in      = lcnt_ff;
      rcnt_in      = rcnt_ff;
      n_in         = n_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      rd_valid_in  = issue;
      rsp_area_in  = rsp_area_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // Every held (low, width) pair is a real candidate, so the running maximum
      // may sample it on every cycle.
      prod_in = PW'(low_ff * width_ff);
      best_in = (prod_ff > best_ff) ? prod_ff : best_ff;

      if (csr_wr_en) begin
         if (csr_index == CSR_ROWS) begin
            rows_in = csr_wdata;
         end else begin
            cols_in = csr_wdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               row_in = req_row;
               col_in = req_col;
               if (req_operation == OP_TOGGLE && in_grid) begin
                  state_in = S_TGL;
               end else if (req_operation == OP_QUERY) begin
                  low_in   = '0;
                  width_in = '0;
                  prod_in  = '0;
                  best_in  = '0;
                  dir_in   = 2'd0;
                  state_in = in_grid ? S_SETUP : S_RESP;
               end
            end
         end
         S_TGL: begin
            state_in = S_IDLE;
         end
         S_SETUP: begin
            k_in     = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (issue) begin
               k_in = k_ff + LW'(1);
            end else begin
               state_in = S_GINIT;
            end
         end
         S_GINIT: begin
            low_in   = c_run;
            width_in = LW'(1);
            lcnt_in  = p_cur;
            rcnt_in  = n_cur - p_cur - LW'(1);
            n_in     = n_cur;
            state_in = S_GREEDY;
         end
         S_GREEDY: begin
            if (go) begin
               width_in = width_ff + LW'(1);
               if (val < low_ff) begin
                  low_in = val;
               end
               if (take_left) begin
                  lcnt_in = lcnt_ff - LW'(1);
               end else begin
                  rcnt_in = rcnt_ff - LW'(1);
               end
            end else if (dir_ff == 2'd3) begin
               state_in = S_FLUSH;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = S_SETUP;
            end
         end
         S_FLUSH: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = (best_wide > SW'(AREA_MAX)) ? AREA_MAX : AREA_W'(best_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= SIZE_RESET;
         cols_ff      <= SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
      end
      dir_ff      <= dir_in;
      k_ff        <= k_in;
      low_ff      <= low_in;
      width_ff    <= width_in;
      lcnt_ff     <= lcnt_in;
      rcnt_ff     <= rcnt_in;
      n_ff        <= n_in;
      prod_ff     <= prod_in;
      best_ff     <= best_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      rsp_area_ff <= rsp_area_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_area  = rsp_area_ff;

`ifndef SYNTHESIS
   // Line data must never reach the cells while the chains are shifting.
   a_no_accum_in_greedy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GREEDY) |-> !rd_valid_ff)
      else $error("line data arrived during the greedy search");

   // The span plus the positions left on both sides always covers the whole line.
   a_span_bookkeeping: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GREEDY) |-> (LW'(width_ff + lcnt_ff + rcnt_ff) == n_ff))
      else $error("greedy span bookkeeping lost a position");

   // No rectangle is larger than the stored grid.
   a_area_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (int'(rsp_area_ff) <= LINE * LINE))
      else $error("area exceeds the grid size");
`endif

endmodule
